### rtl/pf_pkg.sv
`timescale 1ns / 1ps

package pf_pkg;

	// Width of the value under factorisation; the input port stays 32 bits wide.
	localparam int VALUE_WIDTH = 32;
	localparam int IN_WIDTH    = 32;
	localparam int PRIME_WIDTH = 32;
	localparam int EXP_WIDTH   = 5;
	localparam int MAX_RESULTS = 9;

	localparam int CNT_WIDTH  = $clog2(MAX_RESULTS + 1);
	localparam int STEP_WIDTH = $clog2(VALUE_WIDTH);

	localparam logic [EXP_WIDTH-1:0] EXP_MAX = '1;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [EXP_WIDTH-1:0]   exp_t;
	typedef logic [CNT_WIDTH-1:0]   cnt_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_DIV,
		ST_EVAL,
		ST_FIN,
		ST_FLUSH
	} state_t;

	// Quotient and remainder handed back by the shared divider.
	typedef struct packed {
		logic   done;
		value_t quot;
		value_t rem;
	} div_res_t;

endpackage

### rtl/pf_div.sv
`timescale 1ns / 1ps

module pf_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pf_pkg::value_t   dividend,
	input  pf_pkg::value_t   divisor,
	output pf_pkg::div_res_t res
);

	logic                          busy_q;
	logic                          done_q;
	logic [pf_pkg::STEP_WIDTH-1:0] step_q;
	pf_pkg::value_t                quot_q;
	pf_pkg::value_t                rem_q;
	pf_pkg::value_t                divisor_q;
	logic [pf_pkg::VALUE_WIDTH:0]  shifted;
	logic [pf_pkg::VALUE_WIDTH:0]  diff;
	logic                          last_step;

	// One restoring step: bring in the next dividend bit and try a subtraction.
	always_comb begin
		shifted   = {rem_q, quot_q[pf_pkg::VALUE_WIDTH-1]};
		diff      = shifted - {1'b0, divisor_q};
		last_step = (step_q == pf_pkg::STEP_WIDTH'(pf_pkg::VALUE_WIDTH - 1));
	end

	// Control: busy for one step per quotient bit, then a single done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient register doubles as the dividend shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[pf_pkg::VALUE_WIDTH-2:0], ~diff[pf_pkg::VALUE_WIDTH]};
			if (diff[pf_pkg::VALUE_WIDTH]) begin
				rem_q <= shifted[pf_pkg::VALUE_WIDTH-1:0];
			end else begin
				rem_q <= diff[pf_pkg::VALUE_WIDTH-1:0];
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

### rtl/prime_factorizer.sv
`timescale 1ns / 1ps
// A value below 2 goes through the ZERO state to give its single result.
// Otherwise every trial divisor, and every further division by a divisor that divides,
// costs one pass of the bit-serial divider; a 32-bit prime near 2^32 needs about 65536 passes.
// One item is worked on at a time; the next is accepted once the last result is queued.
// Reset clears the sequencer and the output valid flag; the block then waits for an item.

module prime_factorizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pf_pkg::IN_WIDTH-1:0]    value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pf_pkg::PRIME_WIDTH-1:0] prime,
	output logic [pf_pkg::EXP_WIDTH-1:0]   exponent,
	output logic                          none,
	output logic                          last
);

	pf_pkg::state_t   state_q, state_d;
	pf_pkg::div_res_t div_res;
	logic             div_start;

	pf_pkg::value_t rem_q, rem_d;
	pf_pkg::value_t d_q, d_d;
	pf_pkg::exp_t   e_q, e_d;
	pf_pkg::cnt_t   cnt_q, cnt_d;
	logic           pend_valid_q, pend_valid_d;
	pf_pkg::value_t pend_prime_q, pend_prime_d;
	pf_pkg::exp_t   pend_exp_q, pend_exp_d;

	logic                           out_valid_q;
	logic                           out_load;
	logic                           out_none;
	logic                           out_last;
	logic [pf_pkg::PRIME_WIDTH-1:0] prime_q;
	pf_pkg::exp_t                   exponent_q;
	logic                           none_q;
	logic                           last_q;

	pf_pkg::value_t value_in;
	logic           accept;
	logic           out_free;
	logic           head_end;
	logic           divides;
	logic           found;
	pf_pkg::exp_t   e_inc;
	pf_pkg::cnt_t   cnt_inc;

	// Shared remainder unit.
	pf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_d),
		.divisor  (d_d),
		.res      (div_res)
	);

	// Decodes of the division just finished.
	always_comb begin
		value_in = pf_pkg::VALUE_WIDTH'(value);
		accept   = in_valid && (state_q == pf_pkg::ST_IDLE);
		out_free = !out_valid_q;
		head_end = (e_q == '0) && (d_q > div_res.quot);
		divides  = (div_res.rem == '0);
		found    = (e_q != '0) && !divides;
		e_inc    = (e_q == pf_pkg::EXP_MAX) ? e_q : e_q + 1'b1;
		cnt_inc  = cnt_q + 1'b1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (value_in < pf_pkg::value_t'(2)) ? pf_pkg::ST_ZERO
					                                           : pf_pkg::ST_DIV;
				end
			end
			pf_pkg::ST_ZERO: begin
				if (out_free) state_d = pf_pkg::ST_IDLE;
			end
			pf_pkg::ST_DIV: begin
				if (div_res.done) state_d = pf_pkg::ST_EVAL;
			end
			pf_pkg::ST_EVAL: begin
				if (head_end) begin
					state_d = pf_pkg::ST_FIN;
				end else if (found) begin
					if (!(pend_valid_q && !out_free)) begin
						state_d = (cnt_inc == pf_pkg::CNT_WIDTH'(pf_pkg::MAX_RESULTS))
						          ? pf_pkg::ST_FLUSH : pf_pkg::ST_DIV;
					end
				end else begin
					state_d = pf_pkg::ST_DIV;
				end
			end
			pf_pkg::ST_FIN: begin
				if (out_free) state_d = pf_pkg::ST_FLUSH;
			end
			pf_pkg::ST_FLUSH: begin
				if (out_free) state_d = pf_pkg::ST_IDLE;
			end
			default: state_d = pf_pkg::ST_IDLE;
		endcase
	end

	// Datapath control and next values of the working registers.
	always_comb begin
		div_start    = 1'b0;
		out_load     = 1'b0;
		out_none     = 1'b0;
		out_last     = 1'b0;
		rem_d        = rem_q;
		d_d          = d_q;
		e_d          = e_q;
		cnt_d        = cnt_q;
		pend_valid_d = pend_valid_q;
		pend_prime_d = pend_prime_q;
		pend_exp_d   = pend_exp_q;
		case (state_q)
			pf_pkg::ST_IDLE: begin
				rem_d        = value_in;
				d_d          = pf_pkg::value_t'(2);
				e_d          = '0;
				cnt_d        = '0;
				pend_valid_d = 1'b0;
				div_start    = accept && (value_in >= pf_pkg::value_t'(2));
			end
			pf_pkg::ST_ZERO: begin
				out_load = out_free;
				out_none = 1'b1;
				out_last = 1'b1;
			end
			pf_pkg::ST_EVAL: begin
				if (head_end) begin
					// Divisor has passed the square root of what remains.
				end else if (divides) begin
					rem_d     = div_res.quot;
					e_d       = e_inc;
					div_start = 1'b1;
				end else if (found) begin
					// Retire the previous prime before the new one takes its place.
					if (!(pend_valid_q && !out_free)) begin
						out_load     = pend_valid_q;
						pend_valid_d = 1'b1;
						pend_prime_d = d_q;
						pend_exp_d   = e_q;
						cnt_d        = cnt_inc;
						e_d          = '0;
						d_d          = d_q + 1'b1;
						div_start    = (cnt_inc != pf_pkg::CNT_WIDTH'(pf_pkg::MAX_RESULTS));
					end
				end else begin
					d_d       = d_q + 1'b1;
					div_start = 1'b1;
				end
			end
			pf_pkg::ST_FIN: begin
				// A remainder above one is itself a prime with exponent one.
				if (out_free && (rem_q > pf_pkg::value_t'(1))) begin
					out_load     = pend_valid_q;
					pend_valid_d = 1'b1;
					pend_prime_d = rem_q;
					pend_exp_d   = pf_pkg::EXP_WIDTH'(1);
				end
			end
			pf_pkg::ST_FLUSH: begin
				out_load = out_free;
				out_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pf_pkg::ST_IDLE;
			pend_valid_q <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			cnt_q        <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the output item register.
	always_ff @(posedge clk) begin
		rem_q        <= rem_d;
		d_q          <= d_d;
		e_q          <= e_d;
		pend_prime_q <= pend_prime_d;
		pend_exp_q   <= pend_exp_d;
		if (out_load) begin
			prime_q    <= out_none ? '0 : pf_pkg::PRIME_WIDTH'(pend_prime_q);
			exponent_q <= out_none ? '0 : pend_exp_q;
			none_q     <= out_none;
			last_q     <= out_last;
		end
	end

	assign in_stall  = (state_q != pf_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign prime     = prime_q;
	assign exponent  = exponent_q;
	assign none      = none_q;
	assign last      = last_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 100000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int RANDOM_ITEMS   = 80;
	localparam int QUIET_ITEMS    = 20;
	localparam longint unsigned VALUE_MASK = (pf_pkg::VALUE_WIDTH >= 64) ?
		64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << pf_pkg::VALUE_WIDTH) - 64'd1);
	localparam longint unsigned WORD_MAX = 64'h0000_0000_FFFF_FFFF;

	// One factor of a value as the block reports it.
	typedef struct packed {
		logic [pf_pkg::PRIME_WIDTH-1:0] prime;
		logic [pf_pkg::EXP_WIDTH-1:0]   exponent;
		logic                           none;
		logic                           last;
	} factor_t;

	// Factorises each accepted value by trial division and holds the factors still due.
	class factor_board;
		factor_t expected_factors[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function factor_t make_factor(input longint unsigned p, input longint unsigned e);
			factor_t f;
			f.prime    = p[pf_pkg::PRIME_WIDTH-1:0];
			f.exponent = (e > pf_pkg::EXP_MAX) ? pf_pkg::EXP_MAX : e[pf_pkg::EXP_WIDTH-1:0];
			f.none     = 1'b0;
			f.last     = 1'b0;
			return f;
		endfunction

		function void note_value(input logic [pf_pkg::IN_WIDTH-1:0] v);
			longint unsigned rem;
			longint unsigned d;
			longint unsigned e;
			factor_t found[$];
			factor_t f;
			rem = 64'(v) & VALUE_MASK;
			// Zero and one have no prime factors at all.
			if (rem < 2) begin
				f.prime    = '0;
				f.exponent = '0;
				f.none     = 1'b1;
				f.last     = 1'b1;
				expected_factors.push_back(f);
				return;
			end
			// Strip each divisor completely while its square still fits in the remainder.
			for (d = 2; d <= rem / d; d++) begin
				if (rem % d == 0) begin
					e = 0;
					while (rem % d == 0) begin
						e++;
						rem = rem / d;
					end
					if (found.size() < pf_pkg::MAX_RESULTS)
						found.push_back(make_factor(d, e));
				end
			end
			// Whatever is left above one is itself prime.
			if (rem > 1 && found.size() < pf_pkg::MAX_RESULTS)
				found.push_back(make_factor(rem, 1));
			found[found.size() - 1].last = 1'b1;
			foreach (found[i])
				expected_factors.push_back(found[i]);
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_factor(input logic [pf_pkg::PRIME_WIDTH-1:0] p,
				input logic [pf_pkg::EXP_WIDTH-1:0] x, input logic n, input logic l);
			factor_t want;
			if (expected_factors.size() == 0) begin
				report($sformatf("factor %0d^%0d arrived with nothing outstanding", p, x));
				return;
			end
			want = expected_factors.pop_front();
			if (p !== want.prime)
				report($sformatf("prime %0d, expected %0d", p, want.prime));
			if (x !== want.exponent)
				report($sformatf("exponent %0d of %0d, expected %0d", x, want.prime,
					want.exponent));
			if (n !== want.none)
				report($sformatf("none %b for %0d, expected %b", n, want.prime, want.none));
			if (l !== want.last)
				report($sformatf("last %b for %0d, expected %b", l, want.prime, want.last));
		endtask

		function int pending();
			return expected_factors.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [pf_pkg::IN_WIDTH-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [pf_pkg::PRIME_WIDTH-1:0] prime;
	logic [pf_pkg::EXP_WIDTH-1:0] exponent;
	logic none;
	logic last;

	logic pressure_on = 1'b0;
	logic hold_output = 1'b0;
	logic quiet_tail = 1'b0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;

	factor_board board = new;

	// Zero, one, small primes, prime powers, nine distinct primes and all-ones patterns.
	logic [31:0] corner_values [20] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd97, 32'd1024,
		32'h8000_0000, 32'd3486784401, 32'hFFFF_FFFF, 32'd223092870,
		32'd65521, 32'd63001, 32'd4293984256, 32'hAAAA_AAAA, 32'h5555_5555,
		32'd720720, 32'd9699690, 32'd1
	};
	longint unsigned small_primes [15] = '{
		2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47
	};

	prime_factorizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.prime     (prime),
		.exponent  (exponent),
		.none      (none),
		.last      (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Mostly smooth numbers, so that trial division ends quickly, with some small noise.
	function automatic logic [31:0] random_value();
		longint unsigned v;
		longint unsigned p;
		int mode;
		int k;
		mode = $urandom_range(0, 9);
		if (mode < 2)
			return $urandom_range(0, 4095);
		if (mode == 2) begin
			// A single prime raised as far as a random exponent allows.
			p = small_primes[$urandom_range(0, 14)];
			v = p;
			k = $urandom_range(1, 31);
			while (k > 0 && v * p <= WORD_MAX) begin
				v = v * p;
				k--;
			end
			return v[31:0];
		end
		v = 1;
		foreach (small_primes[i]) begin
			if ($urandom_range(0, 2) == 0) begin
				k = $urandom_range(1, 5);
				while (k > 0 && v * small_primes[i] <= WORD_MAX) begin
					v = v * small_primes[i];
					k--;
				end
			end
		end
		p = $urandom_range(1, 4095);
		if (v * p <= WORD_MAX)
			v = v * p;
		return v[31:0];
	endfunction

	// Offers one value, with an optional gap beforehand, and waits for it to be taken.
	task send_value(input logic [31:0] v);
		int gap;
		if (sender_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		board.note_value(v);
	endtask

	// Stimulus: reset, corner values, then random values in blocks of varying idling.
	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_values[i])
			send_value(corner_values[i]);
		pressure_on <= 1'b1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 20 == 0) begin
				sender_idle   = $urandom_range(0, 1);
				receiver_idle = $urandom_range(0, 1);
			end
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet_tail <= 1'b1;
			send_value(random_value());
		end
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("prime_factorizer regression: pass");
		end else begin
			$display("prime_factorizer regression: fail");
		end
		$finish;
	end

	// Receiver: checks each accepted factor and stalls in random bursts.
	initial begin
		int stall_left;
		bit stall_next;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_factor(prime, exponent, none, last);
			if (stall_left == 0 && receiver_idle && !quiet_tail && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 17);
			stall_next = hold_output;
			if (stall_left != 0) begin
				stall_next = 1'b1;
				stall_left--;
			end
			out_stall <= stall_next;
		end
	end

	// One long hold-off on the result side, so that the block backs up onto its input.
	initial begin
		wait (pressure_on);
		@(posedge clk);
		hold_output <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_output <= 1'b0;
	end

	// Watchdog: ends the run when neither side moves an item for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("prime_factorizer regression: fail");
		$finish;
	end

endmodule
